// File: design/ebcalu_pkg.sv
`default_nettype none

package ebcalu_pkg;

  // flag bit positions in a flags nibble
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  typedef enum logic [5:0] {
    CMD_ADD8     = 6'd0,
    CMD_ADC      = 6'd1,
    CMD_SUB      = 6'd2,
    CMD_SBC      = 6'd3,
    CMD_AND      = 6'd4,
    CMD_XOR      = 6'd5,
    CMD_OR       = 6'd6,
    CMD_CP       = 6'd7,
    CMD_INC8     = 6'd8,
    CMD_DEC8     = 6'd9,
    CMD_INC16    = 6'd10,
    CMD_DEC16    = 6'd11,
    CMD_ADD16    = 6'd12,
    CMD_ADD_SP   = 6'd13,
    CMD_LD_HL_SP = 6'd14,
    CMD_DAA      = 6'd15,
    CMD_CPL      = 6'd16,
    CMD_SCF      = 6'd17,
    CMD_CCF      = 6'd18,
    CMD_RLCA     = 6'd19,
    CMD_RRCA     = 6'd20,
    CMD_RLA      = 6'd21,
    CMD_RRA      = 6'd22,
    CMD_RLC      = 6'd23,
    CMD_RRC      = 6'd24,
    CMD_RL       = 6'd25,
    CMD_RR       = 6'd26,
    CMD_SLA      = 6'd27,
    CMD_SRA      = 6'd28,
    CMD_SWAP     = 6'd29,
    CMD_SRL      = 6'd30,
    CMD_BIT      = 6'd31,
    CMD_RES      = 6'd32,
    CMD_SET      = 6'd33
  } cmd_e;

  typedef struct packed {
    logic [5:0]  command;
    logic [15:0] operand_a;
    logic [15:0] operand_b;
    logic [2:0]  bit_index;
    logic [3:0]  flags;
  } op_t;

  typedef struct packed {
    logic [15:0] result;
    logic [3:0]  flags;
  } res_t;

endpackage

`default_nettype wire

// File: design/ebcalu_core.sv
`default_nettype none

module ebcalu_core (
  input  wire ebcalu_pkg::op_t op_i,
  output ebcalu_pkg::res_t     res_o
);

  ebcalu_pkg::cmd_e cmd;
  logic [15:0] a16;
  logic [15:0] b16;
  logic [7:0]  a;
  logic [7:0]  b;
  logic        zi;
  logic        ni;
  logic        hi;
  logic        ci;

  logic        add_cin;
  logic        sub_cin;
  logic [8:0]  add_sum;
  logic [4:0]  add_half;
  logic [8:0]  sub_diff;
  logic [4:0]  sub_half;
  logic [16:0] add16_sum;
  logic [12:0] add16_half;
  logic [15:0] sp_sum;
  logic [4:0]  sp_half;
  logic [8:0]  sp_byte;
  logic [7:0]  bit_mask;
  logic [7:0]  daa_adj;
  logic        daa_c;
  logic [7:0]  r8;
  logic        sh_c;

  assign cmd = ebcalu_pkg::cmd_e'(op_i.command);
  assign a16 = op_i.operand_a;
  assign b16 = op_i.operand_b;
  assign a   = a16[7:0];
  assign b   = b16[7:0];
  assign zi  = op_i.flags[ebcalu_pkg::FlagZ];
  assign ni  = op_i.flags[ebcalu_pkg::FlagN];
  assign hi  = op_i.flags[ebcalu_pkg::FlagH];
  assign ci  = op_i.flags[ebcalu_pkg::FlagC];

  assign add_cin    = (cmd == ebcalu_pkg::CMD_ADC) && ci;
  assign sub_cin    = (cmd == ebcalu_pkg::CMD_SBC) && ci;
  assign add_sum    = {1'b0, a} + {1'b0, b} + {8'd0, add_cin};
  assign add_half   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, add_cin};
  // borrow out of the top bit is the carry flag
  assign sub_diff   = {1'b0, a} - {1'b0, b} - {8'd0, sub_cin};
  assign sub_half   = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, sub_cin};
  assign add16_sum  = {1'b0, a16} + {1'b0, b16};
  assign add16_half = {1'b0, a16[11:0]} + {1'b0, b16[11:0]};
  assign sp_sum     = a16 + {{8{b[7]}}, b};
  assign sp_half    = {1'b0, a16[3:0]} + {1'b0, b[3:0]};
  assign sp_byte    = {1'b0, a16[7:0]} + {1'b0, b};
  assign bit_mask   = 8'd1 << op_i.bit_index;

  always_comb begin
    daa_adj = 8'h00;
    daa_c   = ci;
    if (!ni) begin
      if (ci || (a > 8'h99)) begin
        daa_adj[6:5] = 2'b11;
        daa_c        = 1'b1;
      end
      if (hi || (a[3:0] > 4'd9)) begin
        daa_adj[2:1] = 2'b11;
      end
    end else begin
      if (ci) begin
        daa_adj[6:5] = 2'b11;
      end
      if (hi) begin
        daa_adj[2:1] = 2'b11;
      end
    end
  end

  // prefixed rotate and shift group
  always_comb begin
    r8   = a;
    sh_c = 1'b0;
    case (cmd)
      ebcalu_pkg::CMD_RLC: begin
        r8   = {a[6:0], a[7]};
        sh_c = a[7];
      end
      ebcalu_pkg::CMD_RRC: begin
        r8   = {a[0], a[7:1]};
        sh_c = a[0];
      end
      ebcalu_pkg::CMD_RL: begin
        r8   = {a[6:0], ci};
        sh_c = a[7];
      end
      ebcalu_pkg::CMD_RR: begin
        r8   = {ci, a[7:1]};
        sh_c = a[0];
      end
      ebcalu_pkg::CMD_SLA: begin
        r8   = {a[6:0], 1'b0};
        sh_c = a[7];
      end
      ebcalu_pkg::CMD_SRA: begin
        r8   = {a[7], a[7:1]};
        sh_c = a[0];
      end
      ebcalu_pkg::CMD_SWAP: begin
        r8   = {a[3:0], a[7:4]};
        sh_c = 1'b0;
      end
      default: begin
        r8   = {1'b0, a[7:1]};
        sh_c = a[0];
      end
    endcase
  end

  always_comb begin
    res_o.result = a16;
    res_o.flags  = op_i.flags;
    case (cmd)
      ebcalu_pkg::CMD_ADD8, ebcalu_pkg::CMD_ADC: begin
        res_o.result = {8'h00, add_sum[7:0]};
        res_o.flags  = {add_sum[7:0] == 8'h00, 1'b0, add_half[4], add_sum[8]};
      end
      ebcalu_pkg::CMD_SUB, ebcalu_pkg::CMD_SBC: begin
        res_o.result = {8'h00, sub_diff[7:0]};
        res_o.flags  = {sub_diff[7:0] == 8'h00, 1'b1, sub_half[4], sub_diff[8]};
      end
      ebcalu_pkg::CMD_CP: begin
        res_o.flags = {sub_diff[7:0] == 8'h00, 1'b1, sub_half[4], sub_diff[8]};
      end
      ebcalu_pkg::CMD_AND: begin
        res_o.result = {8'h00, a & b};
        res_o.flags  = {(a & b) == 8'h00, 1'b0, 1'b1, 1'b0};
      end
      ebcalu_pkg::CMD_XOR: begin
        res_o.result = {8'h00, a ^ b};
        res_o.flags  = {(a ^ b) == 8'h00, 3'b000};
      end
      ebcalu_pkg::CMD_OR: begin
        res_o.result = {8'h00, a | b};
        res_o.flags  = {(a | b) == 8'h00, 3'b000};
      end
      ebcalu_pkg::CMD_INC8: begin
        res_o.result = {8'h00, a + 8'd1};
        res_o.flags  = {a == 8'hFF, 1'b0, a[3:0] == 4'hF, ci};
      end
      ebcalu_pkg::CMD_DEC8: begin
        res_o.result = {8'h00, a - 8'd1};
        res_o.flags  = {a == 8'h01, 1'b1, a[3:0] == 4'h0, ci};
      end
      ebcalu_pkg::CMD_INC16: begin
        res_o.result = a16 + 16'd1;
      end
      ebcalu_pkg::CMD_DEC16: begin
        res_o.result = a16 - 16'd1;
      end
      ebcalu_pkg::CMD_ADD16: begin
        res_o.result = add16_sum[15:0];
        res_o.flags  = {zi, 1'b0, add16_half[12], add16_sum[16]};
      end
      ebcalu_pkg::CMD_ADD_SP, ebcalu_pkg::CMD_LD_HL_SP: begin
        res_o.result = sp_sum;
        res_o.flags  = {2'b00, sp_half[4], sp_byte[8]};
      end
      ebcalu_pkg::CMD_DAA: begin
        if (!ni) begin
          res_o.result = {8'h00, a + daa_adj};
        end else begin
          res_o.result = {8'h00, a - daa_adj};
        end
        res_o.flags = {res_o.result[7:0] == 8'h00, ni, 1'b0, daa_c};
      end
      ebcalu_pkg::CMD_CPL: begin
        res_o.result = {8'h00, ~a};
        res_o.flags  = {zi, 1'b1, 1'b1, ci};
      end
      ebcalu_pkg::CMD_SCF: begin
        res_o.flags = {zi, 1'b0, 1'b0, 1'b1};
      end
      ebcalu_pkg::CMD_CCF: begin
        res_o.flags = {zi, 1'b0, 1'b0, !ci};
      end
      ebcalu_pkg::CMD_RLCA: begin
        res_o.result = {8'h00, a[6:0], a[7]};
        res_o.flags  = {3'b000, a[7]};
      end
      ebcalu_pkg::CMD_RRCA: begin
        res_o.result = {8'h00, a[0], a[7:1]};
        res_o.flags  = {3'b000, a[0]};
      end
      ebcalu_pkg::CMD_RLA: begin
        res_o.result = {8'h00, a[6:0], ci};
        res_o.flags  = {3'b000, a[7]};
      end
      ebcalu_pkg::CMD_RRA: begin
        res_o.result = {8'h00, ci, a[7:1]};
        res_o.flags  = {3'b000, a[0]};
      end
      ebcalu_pkg::CMD_RLC, ebcalu_pkg::CMD_RRC, ebcalu_pkg::CMD_RL, ebcalu_pkg::CMD_RR,
      ebcalu_pkg::CMD_SLA, ebcalu_pkg::CMD_SRA, ebcalu_pkg::CMD_SWAP,
      ebcalu_pkg::CMD_SRL: begin
        res_o.result = {8'h00, r8};
        res_o.flags  = {r8 == 8'h00, 2'b00, sh_c};
      end
      ebcalu_pkg::CMD_BIT: begin
        res_o.flags = {(a & bit_mask) == 8'h00, 1'b0, 1'b1, ci};
      end
      ebcalu_pkg::CMD_RES: begin
        res_o.result = {8'h00, a & ~bit_mask};
      end
      ebcalu_pkg::CMD_SET: begin
        res_o.result = {8'h00, a | bit_mask};
      end
      default: begin
        // unused codes pass operand and flags through
        res_o.result = a16;
        res_o.flags  = op_i.flags;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/eight_bit_cpu_alu_with_flags_unit.sv
`default_nettype none

// SM83-style ALU with flags. One operation is accepted per clock while in_ready_o
// is high: the transaction is held in an input register, passes the single-pass
// ALU logic, and lands in the result register, so its result is valid on the
// output once it is in the result register and held until it is taken. With
// out_ready_i held high the unit sustains one transaction per cycle; when the
// output stalls, the input register still takes one more transaction before
// in_ready_o drops. Flags are packed as Z N H C, bit 3 to 0.
module eight_bit_cpu_alu_with_flags_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [5:0]  command_i,
  input  wire logic [15:0] operand_a_i,
  input  wire logic [15:0] operand_b_i,
  input  wire logic [2:0]  bit_index_i,
  input  wire logic [3:0]  flags_in_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [15:0]      result_o,
  output logic [3:0]       flags_out_o
);

  logic              op_valid_q;
  ebcalu_pkg::op_t   op_q;
  ebcalu_pkg::res_t  alu_res;
  logic              res_valid_q;
  ebcalu_pkg::res_t  res_q;
  logic              res_load;
  logic              op_load;

  // result register free, or draining this cycle
  assign res_load   = op_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !op_valid_q || res_load;
  assign op_load    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      op_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_load) begin
      op_q <= '{command:   command_i,
                operand_a: operand_a_i,
                operand_b: operand_b_i,
                bit_index: bit_index_i,
                flags:     flags_in_i};
    end
  end

  ebcalu_core u_core (
    .op_i  (op_q),
    .res_o (alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (!res_valid_q || out_ready_i) begin
      res_valid_q <= op_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= alu_res;
    end
  end

  assign out_valid_o = res_valid_q;
  assign result_o    = res_q.result;
  assign flags_out_o = res_q.flags;

`ifndef SYNTHESIS
  a_accept_fills_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_load |=> op_valid_q)
    else $error("accepted transaction did not reach the input register");

  a_op_moves_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |=> out_valid_o)
    else $error("input register advanced but no result is valid");

  a_stall_holds_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_valid_q && !res_load) |=> (op_valid_q && $stable(op_q)))
    else $error("stalled transaction in input register was lost or changed");

  a_ready_low_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (op_valid_q && out_valid_o && !out_ready_i))
    else $error("input stalled while the pipeline had room");
`endif

endmodule

`default_nettype wire
